>>> src/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Types and constants shared by the LRU key-value cache and its cells.
// ----------------------------------------------------------------------------
package lkv_pkg;

	localparam int KEY_W  = 32;
	localparam int DATA_W = 32;
	localparam int CAP_W  = 5;

	localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

	// Command codes carried in a request item
	localparam logic CMD_SET = 1'b0;
	localparam logic CMD_GET = 1'b1;

	// Value returned on a miss
	localparam logic signed [DATA_W-1:0] MISS_DATA = '1;

	typedef struct packed {
		logic                     command;
		logic signed [KEY_W-1:0]  key;
		logic signed [DATA_W-1:0] data_in;
	} lkv_req_t;

	typedef struct packed {
		logic                     hit;
		logic signed [DATA_W-1:0] data_out;
	} lkv_rsp_t;

	typedef struct packed {
		logic shift;
		logic load;
	} lkv_cell_ctrl_t;

endpackage

>>> src/lkv_cell.sv
// ----------------------------------------------------------------------------
// lkv_cell
// One recency position of the cache: holds a key and its value, compares
// the key against the lookup key, and takes the entry of its younger
// neighbour on a shift or a fresh entry on a load.
// ----------------------------------------------------------------------------
module lkv_cell
	import lkv_pkg::*;
(
	input  logic                     clk,
	input  lkv_cell_ctrl_t           ctrl,
	input  logic signed [KEY_W-1:0]  next_key,
	input  logic signed [DATA_W-1:0] next_value,
	input  logic signed [KEY_W-1:0]  load_key,
	input  logic signed [DATA_W-1:0] load_value,
	input  logic signed [KEY_W-1:0]  lookup_key,
	output logic signed [KEY_W-1:0]  key,
	output logic signed [DATA_W-1:0] value,
	output logic                     match
);

	logic signed [KEY_W-1:0]  key_q;
	logic signed [DATA_W-1:0] value_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			key_q   <= load_key;
			value_q <= load_value;
		end else if (ctrl.shift) begin
			key_q   <= next_key;
			value_q <= next_value;
		end
	end

	assign key   = key_q;
	assign value = value_q;
	assign match = (key_q == lookup_key);

endmodule

>>> src/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// The store is a row of MAX_ENTRIES cells kept in recency order, oldest in
// cell 0. A request item is taken in ST_IDLE and resolved in ST_LOOKUP: all
// cells compare their key at once, the oldest match wins, and the cells from
// the hit (or from cell 0 on an eviction) up to the one below the youngest
// valid cell take their neighbour's entry while the youngest valid cell takes
// the touched or new entry. No new item is taken until the last is resolved;
// a get also waits while an earlier response is still stalled in the output
// register. A set gives no response; a get gives one, with hit clear and
// all-ones data on a miss. Capacity is read as 1 when written 0 and is capped
// at MAX_ENTRIES; write it only while the cache is idle.
module lru_key_value_cache
	import lkv_pkg::*;
#(
	parameter int MAX_ENTRIES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             capacity_wr_en,
	input  logic [CAP_W-1:0] capacity_data,
	input  logic             req_valid,
	output logic             req_stall,
	input  lkv_req_t         req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output lkv_rsp_t         rsp
);

	localparam int PW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int EW = (CW > CAP_W) ? CW : CAP_W;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_LOOKUP = 2'b10
	} state_t;

	state_t           state_q;
	lkv_req_t         req_s1;
	logic             rsp_valid_q;
	lkv_rsp_t         rsp_q;
	logic [CW-1:0]    used_q;
	logic [CAP_W-1:0] capacity_q;

	lkv_cell_ctrl_t           cell_ctrl  [MAX_ENTRIES];
	logic signed [KEY_W-1:0]  cell_key   [MAX_ENTRIES];
	logic signed [DATA_W-1:0] cell_value [MAX_ENTRIES];
	logic signed [KEY_W-1:0]  next_key   [MAX_ENTRIES];
	logic signed [DATA_W-1:0] next_value [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0]   cell_match;
	logic [MAX_ENTRIES-1:0]   hit_vec;

	logic                     hit_any;
	logic [PW-1:0]            hit_pos;
	logic [EW-1:0]            cap_w;
	logic [EW-1:0]            eff_cap;
	logic                     full;
	logic                     proceed;
	logic                     is_get;
	logic                     do_move;
	logic                     do_load;
	logic                     do_append;
	logic [PW-1:0]            move_lo;
	logic [CW-1:0]            load_tgt;
	logic signed [DATA_W-1:0] load_value;
	logic signed [DATA_W-1:0] hit_value;

	// Row of cells, each handed its younger neighbour's entry
	for (genvar p = 0; p < MAX_ENTRIES; p++) begin : g_cell
		if (p == MAX_ENTRIES - 1) begin : g_last
			assign next_key[p]   = cell_key[p];
			assign next_value[p] = cell_value[p];
		end else begin : g_inner
			assign next_key[p]   = cell_key[p+1];
			assign next_value[p] = cell_value[p+1];
		end

		assign hit_vec[p] = cell_match[p] && (CW'(p) < used_q);

		assign cell_ctrl[p].shift = do_move && (CW'(p) >= CW'(move_lo))
			&& (CW'(p + 1) < used_q);
		assign cell_ctrl[p].load  = do_load && (CW'(p) == load_tgt);

		lkv_cell u_cell (
			.clk        (clk),
			.ctrl       (cell_ctrl[p]),
			.next_key   (next_key[p]),
			.next_value (next_value[p]),
			.load_key   (req_s1.key),
			.load_value (load_value),
			.lookup_key (req_s1.key),
			.key        (cell_key[p]),
			.value      (cell_value[p]),
			.match      (cell_match[p])
		);
	end

	// Oldest matching position wins
	always_comb begin
		hit_pos = '0;
		for (int p = MAX_ENTRIES - 1; p >= 0; p--) begin
			if (hit_vec[p]) begin
				hit_pos = PW'(p);
			end
		end
	end

	assign hit_any   = |hit_vec;
	assign hit_value = cell_value[hit_pos];

	assign cap_w = EW'(capacity_q);
	always_comb begin
		priority if (cap_w == '0) begin
			eff_cap = EW'(1);
		end else if (cap_w > EW'(MAX_ENTRIES)) begin
			eff_cap = EW'(MAX_ENTRIES);
		end else begin
			eff_cap = cap_w;
		end
	end
	assign full = EW'(used_q) >= eff_cap;

	assign is_get  = (req_s1.command == CMD_GET);
	assign proceed = state_q[1] && !(is_get && rsp_valid_q && rsp_stall);

	always_comb begin
		do_move   = 1'b0;
		do_load   = 1'b0;
		do_append = 1'b0;
		move_lo   = hit_pos;
		load_tgt  = used_q - CW'(1);
		if (proceed) begin
			priority if (hit_any) begin
				do_move = 1'b1;
				do_load = 1'b1;
			end else if (is_get) begin
				do_load = 1'b0;
			end else if (full) begin
				// evict the oldest entry
				do_move = 1'b1;
				do_load = 1'b1;
				move_lo = '0;
			end else begin
				do_load   = 1'b1;
				do_append = 1'b1;
				load_tgt  = used_q;
			end
		end
	end

	assign load_value = is_get ? hit_value : req_s1.data_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			used_q      <= '0;
			capacity_q  <= CAPACITY_RESET;
		end else begin
			if (capacity_wr_en) begin
				capacity_q <= capacity_data;
			end
			if (do_append) begin
				used_q <= used_q + CW'(1);
			end
			if (proceed && is_get) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					if (proceed) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q[0] && req_valid) begin
			req_s1 <= req;
		end
		if (proceed && is_get) begin
			rsp_q.hit      <= hit_any;
			rsp_q.data_out <= hit_any ? hit_value : MISS_DATA;
		end
	end

	assign req_stall = !state_q[0];
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> test/lru_cache_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_cache_checker
// Watches the request, response and capacity ports of the LRU key-value
// cache, keeps its own recency-ordered copy of the store, and compares every
// response item against the lookup it predicts.
// ----------------------------------------------------------------------------
module lru_cache_checker
	import lkv_pkg::*;
#(
	parameter int MAX_ENTRIES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             capacity_wr_en,
	input  logic [CAP_W-1:0] capacity_data,
	input  logic             req_valid,
	input  logic             req_stall,
	input  lkv_req_t         req,
	input  logic             rsp_valid,
	input  logic             rsp_stall,
	input  lkv_rsp_t         rsp,
	output int               fail_count,
	output int               pending
);

	typedef struct {
		logic signed [KEY_W-1:0]  key;
		logic signed [DATA_W-1:0] value;
	} lru_entry_t;

	// Resident entries, oldest first
	lru_entry_t       resident[$];
	lkv_rsp_t         expected_lookups[$];
	logic [CAP_W-1:0] capacity_shadow;

	function automatic int usable_slots();
		if (capacity_shadow == '0)
			return 1;
		if (capacity_shadow > MAX_ENTRIES)
			return MAX_ENTRIES;
		return int'(capacity_shadow);
	endfunction

	task automatic apply_request(input lkv_req_t item);
		int         pos;
		lru_entry_t hit_entry;
		lkv_rsp_t   outcome;
		pos = -1;
		for (int i = 0; i < resident.size(); i++) begin
			if (pos < 0 && resident[i].key == item.key)
				pos = i;
		end
		if (item.command == CMD_GET) begin
			if (pos >= 0) begin
				// a hit becomes the most recent entry
				hit_entry = resident[pos];
				resident.delete(pos);
				resident.insert(resident.size(), hit_entry);
				outcome.hit      = 1'b1;
				outcome.data_out = hit_entry.value;
			end else begin
				outcome.hit      = 1'b0;
				outcome.data_out = MISS_DATA;
			end
			expected_lookups.insert(expected_lookups.size(), outcome);
		end else begin
			// an update moves to the young end; a new key at or over capacity
			// drops the oldest, which leaves the count as it is
			if (pos >= 0)
				resident.delete(pos);
			else if (resident.size() >= usable_slots())
				void'(resident.pop_front());
			hit_entry.key   = item.key;
			hit_entry.value = item.data_in;
			resident.insert(resident.size(), hit_entry);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		lkv_rsp_t want;
		if (!arst_n) begin
			resident.delete();
			expected_lookups.delete();
			capacity_shadow = CAPACITY_RESET;
			fail_count      = 0;
		end else begin
			if (capacity_wr_en)
				capacity_shadow = capacity_data;
			if (rsp_valid && !rsp_stall) begin
				if (expected_lookups.size() == 0) begin
					$error("response item with none expected: hit %0b data_out %0d",
						rsp.hit, rsp.data_out);
					fail_count++;
				end else begin
					want = expected_lookups.pop_front();
					if (rsp.hit !== want.hit) begin
						$error("hit: expected %0b, actual %0b", want.hit, rsp.hit);
						fail_count++;
					end
					if (rsp.data_out !== want.data_out) begin
						$error("data_out: expected %0d, actual %0d",
							want.data_out, rsp.data_out);
						fail_count++;
					end
				end
			end
			if (req_valid && !req_stall)
				apply_request(req);
		end
		pending = expected_lookups.size();
	end

endmodule

>>> test/tb_lru_key_value_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache
// Drives set and get items through the LRU key-value cache under a series of
// capacity settings, with random idling on both channels and one long
// response hold-off, and reports the verdict from the checker's count.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache;
	import lkv_pkg::*;

	localparam int POOL_N       = 32;
	localparam int PHASE_ITEMS  = 150;
	localparam int N_PHASES     = 11;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 400000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             capacity_wr_en;
	logic [CAP_W-1:0] capacity_data;
	logic             req_valid;
	logic             req_stall;
	lkv_req_t         req;
	logic             rsp_valid;
	logic             rsp_stall;
	lkv_rsp_t         rsp;
	int               fail_count;
	int               pending;

	bit quiet;
	bit gaps_on;
	bit hold_pending;

	logic signed [KEY_W-1:0] key_pool [POOL_N];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	lru_key_value_cache u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.capacity_wr_en(capacity_wr_en),
		.capacity_data (capacity_data),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req           (req),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.rsp           (rsp)
	);

	lru_cache_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.capacity_wr_en(capacity_wr_en),
		.capacity_data (capacity_data),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req           (req),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.rsp           (rsp),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$error("timeout after %0d cycles", CYCLE_LIMIT);
		$display("status: fail");
		$finish;
	end

	// Response side: random stall bursts, one long hold-off on request
	initial begin : rsp_stall_gen
		bit v;
		int n;
		rsp_stall <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (quiet) begin
				v = 1'b0;
				n = 1;
			end else if (hold_pending) begin
				hold_pending = 1'b0;
				v = 1'b1;
				n = LONG_HOLD;
			end else begin
				v = ($urandom_range(0, 2) == 0);
				n = v ? $urandom_range(1, 14) : $urandom_range(1, 40);
			end
			rsp_stall <= v;
			repeat (n) @(posedge clk);
		end
	end

	// Offer one item and hold it until it is taken
	task automatic send_request(input logic cmd, input logic signed [KEY_W-1:0] k,
		input logic signed [DATA_W-1:0] d);
		lkv_req_t item;
		bit       taken;
		if (gaps_on && !quiet && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		item.command = cmd;
		item.key     = k;
		item.data_in = d;
		req_valid <= 1'b1;
		req       <= item;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !req_stall;
			@(posedge clk);
		end
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] value);
		wait_drained();
		capacity_wr_en <= 1'b1;
		capacity_data  <= value;
		@(posedge clk);
		capacity_wr_en <= 1'b0;
	endtask

	initial begin : stimulus
		logic [CAP_W-1:0] phase_caps [N_PHASES];
		logic             cmd;
		logic signed [KEY_W-1:0] k;
		int pool_n;

		phase_caps = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd4, 5'd8, 5'd17, 5'd2,
			5'd12, 5'd16, 5'd6};
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7fff_ffff;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hffff_ffff;
		for (int i = 4; i < POOL_N; i++)
			key_pool[i] = $urandom;

		quiet          = 1'b0;
		gaps_on        = 1'b1;
		hold_pending   = 1'b0;
		req_valid      <= 1'b0;
		req            <= '0;
		capacity_wr_en <= 1'b0;
		capacity_data  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// empty store, extreme keys and values, update, miss
		send_request(CMD_GET, 32'h0000_0000, 32'h1111_1111);
		send_request(CMD_SET, 32'h8000_0000, 32'h7fff_ffff);
		send_request(CMD_SET, 32'h7fff_ffff, 32'h8000_0000);
		send_request(CMD_SET, 32'h0000_0000, 32'h0000_0000);
		send_request(CMD_SET, 32'hffff_ffff, 32'hffff_ffff);
		send_request(CMD_GET, 32'h8000_0000, 32'h0000_0000);
		send_request(CMD_GET, 32'h7fff_ffff, 32'hffff_ffff);
		send_request(CMD_GET, 32'h0000_0000, 32'h0000_0000);
		send_request(CMD_GET, 32'hffff_ffff, 32'h0000_0000);
		send_request(CMD_SET, 32'h0000_0000, 32'h1234_5678);
		send_request(CMD_GET, 32'h0000_0000, 32'h0000_0000);
		send_request(CMD_GET, 32'h0000_0005, 32'h0000_0000);
		// capacity lowered below the entries in use
		write_capacity(5'd1);
		send_request(CMD_SET, 32'h0000_004d, 32'h55aa_55aa);
		send_request(CMD_GET, 32'h8000_0000, 32'h0000_0000);
		send_request(CMD_GET, 32'h0000_0000, 32'h0000_0000);
		send_request(CMD_GET, 32'h0000_004d, 32'h0000_0000);
		// capacity zero behaves as one
		write_capacity(5'd0);
		send_request(CMD_SET, 32'h0000_0058, 32'ha5a5_a5a5);
		send_request(CMD_GET, 32'h0000_0058, 32'h0000_0000);
		send_request(CMD_GET, 32'h0000_004d, 32'h0000_0000);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			write_capacity(phase_caps[ph]);
			pool_n = (phase_caps[ph] == 0 ? 1 : int'(phase_caps[ph])) + $urandom_range(0, 6);
			if (pool_n > POOL_N)
				pool_n = POOL_N;
			if (ph == N_PHASES - 1)
				quiet = 1'b1;
			if (ph == 2) begin
				// hold responses back and keep offering gets so the block fills
				hold_pending = 1'b1;
				gaps_on = 1'b0;
				repeat (40)
					send_request(CMD_GET, key_pool[$urandom_range(0, pool_n - 1)], $urandom);
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i % 50 == 0)
					gaps_on = ($urandom_range(0, 3) != 0);
				cmd = $urandom_range(0, 1) ? CMD_GET : CMD_SET;
				k = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, pool_n - 1)];
				send_request(cmd, k, $urandom);
			end
		end

		wait_drained();
		if (fail_count == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> filelist.f
src/lkv_pkg.sv
src/lkv_cell.sv
src/lru_key_value_cache.sv
test/lru_cache_checker.sv
test/tb_lru_key_value_cache.sv
